@@ sv/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared constants and types of the heightmap ring flatten pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hrf_pkg;

  localparam int MAP_SIZE   = 1024;
  localparam int COORD_W    = 10;
  localparam int HEIGHT_W   = 8;
  localparam int RADIUS_W   = 11;
  localparam int D2_W       = 21;  // 2 * 1023^2 fits
  localparam int SQ_IN_W    = 37;  // d2 with 16 zero bits below
  localparam int ROOT_W     = 19;  // 8 fraction bits
  localparam int SQRT_STEPS = 19;
  localparam int RATIO_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER   = 3'd4;

  typedef enum logic [1:0] {
    K_PASS,
    K_INNER,
    K_RING
  } kind_t;

  // sideband that travels with each item through the pipeline
  typedef struct packed {
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [HEIGHT_W-1:0] h;
    kind_t               kind;
  } item_t;

endpackage

`default_nettype wire

@@ sv/hrf_pix_if.sv @@
// ----------------------------------------------------------------------------
// hrf_pix_if
// Input pixel channel: valid/ready with column, row and height.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrf_pix_if;
  logic                          valid;
  logic                          ready;
  logic [hrf_pkg::COORD_W-1:0]   pixel_x;
  logic [hrf_pkg::COORD_W-1:0]   pixel_y;
  logic [hrf_pkg::HEIGHT_W-1:0]  height_in;

  modport source (output valid, pixel_x, pixel_y, height_in, input ready);
  modport sink (input valid, pixel_x, pixel_y, height_in, output ready);
endinterface

`default_nettype wire

@@ sv/hrf_res_if.sv @@
// ----------------------------------------------------------------------------
// hrf_res_if
// Result channel: valid/ready with new height, column and row.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrf_res_if;
  logic                          valid;
  logic                          ready;
  logic [hrf_pkg::HEIGHT_W-1:0]  height_out;
  logic [hrf_pkg::COORD_W-1:0]   pixel_x_out;
  logic [hrf_pkg::COORD_W-1:0]   pixel_y_out;

  modport source (output valid, height_out, pixel_x_out, pixel_y_out, input ready);
  modport sink (input valid, height_out, pixel_x_out, pixel_y_out, output ready);
endinterface

`default_nettype wire

@@ sv/hrf_sqrt.sv @@
// ----------------------------------------------------------------------------
// hrf_sqrt
// Pipelined bit-by-bit integer square root of d2 << 16, one result bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_sqrt (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire                              in_valid,
  input  hrf_pkg::item_t                   in_item,
  input  wire  [hrf_pkg::D2_W-1:0]         in_d2,
  output logic                             out_valid,
  output hrf_pkg::item_t                   out_item,
  output logic [hrf_pkg::ROOT_W-1:0]       out_root
);

  localparam int N = hrf_pkg::SQRT_STEPS;
  localparam int W = hrf_pkg::SQ_IN_W;

  logic           valid [N];
  hrf_pkg::item_t item  [N];
  logic [W-1:0]   rem   [N];
  logic [W-1:0]   res   [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2 * k);
      logic           v_in;
      hrf_pkg::item_t i_in;
      logic [W-1:0]   rem_in;
      logic [W-1:0]   res_in;
      logic [W-1:0]   trial;

      if (k == 0) begin : g_first
        assign v_in   = in_valid;
        assign i_in   = in_item;
        assign rem_in = {in_d2, 16'b0};
        assign res_in = '0;
      end else begin : g_next
        assign v_in   = valid[k-1];
        assign i_in   = item[k-1];
        assign rem_in = rem[k-1];
        assign res_in = res[k-1];
      end

      assign trial = res_in + BIT;

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k] <= 1'b0;
        end else if (en) begin
          valid[k] <= v_in;
        end
        if (en) begin
          item[k] <= i_in;
          if (rem_in >= trial) begin
            rem[k] <= rem_in - trial;
            res[k] <= (res_in >> 1) + BIT;
          end else begin
            rem[k] <= rem_in;
            res[k] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign out_valid = valid[N-1];
  assign out_item  = item[N-1];
  assign out_root  = res[N-1][hrf_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ sv/hrf_div.sv @@
// ----------------------------------------------------------------------------
// hrf_div
// Pipelined restoring divider: (step << 8) / width, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrf_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire                              in_valid,
  input  hrf_pkg::item_t                   in_item,
  input  wire  [hrf_pkg::ROOT_W-1:0]       in_step,
  input  wire  [hrf_pkg::RADIUS_W-1:0]     in_width,
  output logic                             out_valid,
  output hrf_pkg::item_t                   out_item,
  output logic [hrf_pkg::RATIO_W-1:0]      out_quot
);

  localparam int N  = hrf_pkg::RATIO_W;
  localparam int RW = hrf_pkg::RADIUS_W;

  logic           valid [N];
  hrf_pkg::item_t item  [N];
  logic [RW-1:0]  rem   [N];
  logic [RW-1:0]  wid   [N];
  logic [N-1:0]   lo    [N];
  logic [N-1:0]   quot  [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic           v_in;
      hrf_pkg::item_t i_in;
      logic [RW-1:0]  rem_in;
      logic [RW-1:0]  wid_in;
      logic [N-1:0]   lo_in;
      logic [N-1:0]   q_in;
      logic [RW:0]    shifted;

      if (k == 0) begin : g_first
        // quotient fits 16 bits in the ring, so the top numerator bits start as remainder
        assign v_in   = in_valid;
        assign i_in   = in_item;
        assign rem_in = in_step[hrf_pkg::ROOT_W-1:8];
        assign wid_in = in_width;
        assign lo_in  = {in_step[7:0], 8'b0};
        assign q_in   = '0;
      end else begin : g_next
        assign v_in   = valid[k-1];
        assign i_in   = item[k-1];
        assign rem_in = rem[k-1];
        assign wid_in = wid[k-1];
        assign lo_in  = lo[k-1];
        assign q_in   = quot[k-1];
      end

      assign shifted = {rem_in, lo_in[N-1-k]};

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k] <= 1'b0;
        end else if (en) begin
          valid[k] <= v_in;
        end
        if (en) begin
          item[k] <= i_in;
          wid[k]  <= wid_in;
          lo[k]   <= lo_in;
          if (shifted >= {1'b0, wid_in}) begin
            rem[k]  <= RW'(shifted - {1'b0, wid_in});
            quot[k] <= {q_in[N-2:0], 1'b1};
          end else begin
            rem[k]  <= shifted[RW-1:0];
            quot[k] <= {q_in[N-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign out_valid = valid[N-1];
  assign out_item  = item[N-1];
  assign out_quot  = quot[N-1];

endmodule

`default_nettype wire

@@ sv/heightmap_ring_flatten.sv @@
// ----------------------------------------------------------------------------
// heightmap_ring_flatten
// Radial flatten and blend of one heightmap pixel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries one pixel (column, row, height) per item; res returns the new
//   height with the column and row passed along, one result per item, in order.
//   Configuration is written through cfg_we / cfg_index / cfg_data while the
//   pipeline is empty; indexes outside the register list are ignored.
// Pipeline: from accept to result valid, 3 front stages, 19 square
//   root stages, step stage, 16 divider stages, product stage, output register.
// Throughput: one item per cycle while the output is not stalled; set by the single shared pipeline advance.
// Reset: the configuration registers clear to zero and every stage is emptied.
// Stall: when a result waits and res.ready is low, the whole pipeline holds
//   and pix.ready drops, empty stages included; it advances while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_ring_flatten (
  input  wire                                 clk,
  input  wire                                 rst,
  hrf_pix_if.sink                             pix,
  hrf_res_if.source                           res,
  input  wire                                 cfg_we,
  input  wire  [hrf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [hrf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW = hrf_pkg::COORD_W;
  localparam int HW = hrf_pkg::HEIGHT_W;
  localparam int RW = hrf_pkg::RADIUS_W;

  logic [HW-1:0]   target_height;
  logic [CW-1:0]   center_x;
  logic [CW-1:0]   center_y;
  logic [RW-1:0]   inner_radius;
  logic [RW-1:0]   outer_radius;
  logic [2*RW-1:0] in2;
  logic [2*RW-1:0] out2;
  logic            ring_ok;

  logic en;

  logic                 s1_valid;
  hrf_pkg::item_t       s1_item;
  logic [CW-1:0]        s1_dx;
  logic [CW-1:0]        s1_dy;
  logic                 s2_valid;
  hrf_pkg::item_t       s2_item;
  logic [2*CW-1:0]      s2_sqx;
  logic [2*CW-1:0]      s2_sqy;
  logic                 s3_valid;
  hrf_pkg::item_t       s3_item;
  logic [hrf_pkg::D2_W-1:0] s3_d2;

  logic                       q_valid;
  hrf_pkg::item_t             q_item;
  logic [hrf_pkg::ROOT_W-1:0] q_root;
  logic [hrf_pkg::ROOT_W-1:0] base;

  logic                       s4_valid;
  hrf_pkg::item_t             s4_item;
  logic [hrf_pkg::ROOT_W-1:0] s4_step;
  logic [RW-1:0]              s4_width;

  logic                        d_valid;
  hrf_pkg::item_t              d_item;
  logic [hrf_pkg::RATIO_W-1:0] d_quot;

  logic                 s5_valid;
  hrf_pkg::item_t       s5_item;
  logic [23:0]          s5_ph;
  logic [24:0]          s5_pt;
  logic [24:0]          blend;

  logic                 out_valid;
  logic [HW-1:0]        out_h;
  logic [CW-1:0]        out_x;
  logic [CW-1:0]        out_y;

  hrf_pkg::item_t       in_item;
  hrf_pkg::item_t       s3_next;
  logic [hrf_pkg::D2_W-1:0] d2_sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_height <= '0;
      center_x      <= '0;
      center_y      <= '0;
      inner_radius  <= '0;
      outer_radius  <= '0;
      in2           <= '0;
      out2          <= '0;
      ring_ok       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hrf_pkg::REG_TARGET:  target_height <= cfg_data[HW-1:0];
          hrf_pkg::REG_CENTERX: center_x      <= cfg_data[CW-1:0];
          hrf_pkg::REG_CENTERY: center_y      <= cfg_data[CW-1:0];
          hrf_pkg::REG_INNER:   inner_radius  <= cfg_data[RW-1:0];
          hrf_pkg::REG_OUTER:   outer_radius  <= cfg_data[RW-1:0];
          default: ;
        endcase
      end
      in2     <= inner_radius * inner_radius;
      out2    <= outer_radius * outer_radius;
      ring_ok <= inner_radius < outer_radius;
    end
  end

  assign en        = !out_valid || res.ready;
  assign pix.ready = en;

  always_comb begin
    in_item.px   = pix.pixel_x;
    in_item.py   = pix.pixel_y;
    in_item.h    = pix.height_in;
    // provisional: in map means candidate, refined after distance
    in_item.kind = (({1'b0, pix.pixel_x} < (CW + 1)'(hrf_pkg::MAP_SIZE)) &&
                    ({1'b0, pix.pixel_y} < (CW + 1)'(hrf_pkg::MAP_SIZE)))
                   ? hrf_pkg::K_RING : hrf_pkg::K_PASS;
  end

  assign d2_sum = {1'b0, s2_sqx} + {1'b0, s2_sqy};

  always_comb begin
    s3_next = s2_item;
    if (s2_item.kind != hrf_pkg::K_PASS) begin
      if ({1'b0, d2_sum} < in2) begin
        s3_next.kind = hrf_pkg::K_INNER;
      end else if ({1'b0, d2_sum} < out2 && ring_ok) begin
        s3_next.kind = hrf_pkg::K_RING;
      end else begin
        s3_next.kind = hrf_pkg::K_PASS;
      end
    end
  end

  // front stages: distance, squares, sum and classify
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pix.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    if (en) begin
      s1_item <= in_item;
      s1_dx   <= (pix.pixel_x > center_x) ? pix.pixel_x - center_x
                                          : center_x - pix.pixel_x;
      s1_dy   <= (pix.pixel_y > center_y) ? pix.pixel_y - center_y
                                          : center_y - pix.pixel_y;
      s2_item <= s1_item;
      s2_sqx  <= s1_dx * s1_dx;
      s2_sqy  <= s1_dy * s1_dy;
      s3_item <= s3_next;
      s3_d2   <= d2_sum;
    end
  end

  hrf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_item   (s3_item),
    .in_d2     (s3_d2),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_root  (q_root)
  );

  assign base = {inner_radius, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= q_valid;
    end
    if (en) begin
      s4_item  <= q_item;
      s4_step  <= (q_root >= base) ? q_root - base : '0;
      s4_width <= outer_radius - inner_radius;
    end
  end

  hrf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .in_item   (s4_item),
    .in_step   (s4_step),
    .in_width  (s4_width),
    .out_valid (d_valid),
    .out_item  (d_item),
    .out_quot  (d_quot)
  );

  assign blend = {1'b0, s5_ph} + s5_pt;

  // blend products, then the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s5_valid  <= d_valid;
      out_valid <= s5_valid;
    end
    if (en) begin
      s5_item <= d_item;
      s5_ph   <= 24'(d_item.h) * 24'(d_quot);
      s5_pt   <= 25'(target_height) * (25'h10000 - 25'(d_quot));
      out_x   <= s5_item.px;
      out_y   <= s5_item.py;
      case (s5_item.kind)
        hrf_pkg::K_INNER: out_h <= target_height;
        hrf_pkg::K_RING:  out_h <= blend[23:16];
        default:          out_h <= s5_item.h;
      endcase
    end
  end

  assign res.valid       = out_valid;
  assign res.height_out  = out_h;
  assign res.pixel_x_out = out_x;
  assign res.pixel_y_out = out_y;

`ifndef SYNTHESIS
  a_inner_gets_target: assert property (@(posedge clk) disable iff (rst)
    en && s5_valid && s5_item.kind == hrf_pkg::K_INNER |=>
      out_valid && res.height_out == target_height)
    else $error("inner disk item did not take target height");

  a_root_above_inner: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_item.kind == hrf_pkg::K_RING |-> q_root >= base)
    else $error("ring item root below inner radius");
`endif

endmodule

`default_nettype wire
